@@ hdl/cptb_pkg.sv @@
// Shared types and constants for the cascaded prescaled timer bank.
// Holds the item structs, opcode codes, control byte layout and prescale masks.
// No dependencies.
package cptb_pkg;

    // Cycle count width; the count advances on executed tick items
    localparam int CYCLE_W = 10;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIFO_A_TIMER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIFO_B_TIMER = 1'b1;

    // Control byte layout
    localparam int CTRL_CASCADE = 2;
    localparam int CTRL_IRQ_EN  = 6;
    localparam int CTRL_ENABLE  = 7;

    // Number of timers that can show up in the irq field
    localparam int IRQ_W = 4;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RELOAD  = 2'd1,
        OP_CONTROL = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef struct packed {
        op_t        opcode;
        logic [1:0] timer_select;
        logic       byte_lane;
        logic [7:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [IRQ_W-1:0] irq_pulses;
        logic             fifo_a_pulse;
        logic             fifo_b_pulse;
    } out_item_t;

    // Per-timer events toward the top level
    typedef struct packed {
        logic overflow;
        logic irq;
    } timer_evt_t;

    // Prescale select to cycle count mask
    function automatic logic [CYCLE_W-1:0] prescale_mask(input logic [1:0] sel);
        logic [CYCLE_W-1:0] m;
        case (sel)
            2'd0:    m = 10'd0;
            2'd1:    m = 10'd63;
            2'd2:    m = 10'd255;
            default: m = 10'd1023;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/cptb_timer.sv @@
// One timer channel: reload/control latches, mode bits and the counter.
// Depends on cptb_pkg. Chained through carry_in / evt.overflow for cascade.
module cptb_timer #(
    parameter int COUNTER_WIDTH = 16,
    parameter int TIMER_INDEX   = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     exec,
    input  cptb_pkg::in_item_t       item,
    input  logic [cptb_pkg::CYCLE_W-1:0] cycle_count,
    input  logic                     carry_in,
    output cptb_pkg::timer_evt_t     evt
);
    import cptb_pkg::*;

    logic [COUNTER_WIDTH-1:0] cnt_reg, cnt_next;
    logic [COUNTER_WIDTH-1:0] reload_reg, reload_next;
    logic [15:0]              lat_reload_reg, lat_reload_next;
    logic [1:0]               pend_reg, pend_next;
    logic [7:0]               lat_ctrl_reg, lat_ctrl_next;
    logic                     ctrl_pend_reg, ctrl_pend_next;
    logic [1:0]               presc_reg, presc_next;
    logic                     casc_reg, casc_next;
    logic                     irq_en_reg, irq_en_next;
    logic                     en_reg, en_next;

    logic                     selected;
    logic [15:0]              r16;
    logic [COUNTER_WIDTH-1:0] reload_eff;
    logic [1:0]               presc_eff;
    logic                     casc_eff, irq_eff, en_eff, armed;
    logic [COUNTER_WIDTH-1:0] cnt_start;
    logic [COUNTER_WIDTH:0]   sum;
    logic                     hit, inc, ovf;

    assign selected = (int'(item.timer_select) == TIMER_INDEX);

    // Latch phase: merge pending reload bytes and take the control byte
    always_comb begin
        r16 = 16'(reload_reg);
        if (pend_reg[0]) begin
            r16[7:0] = lat_reload_reg[7:0];
        end
        if (pend_reg[1]) begin
            r16[15:8] = lat_reload_reg[15:8];
        end
        reload_eff = COUNTER_WIDTH'(r16);

        presc_eff = presc_reg;
        casc_eff  = casc_reg;
        irq_eff   = irq_en_reg;
        en_eff    = en_reg;
        armed     = 1'b0;
        if (ctrl_pend_reg) begin
            presc_eff = lat_ctrl_reg[1:0];
            irq_eff   = lat_ctrl_reg[CTRL_IRQ_EN];
            en_eff    = lat_ctrl_reg[CTRL_ENABLE];
            casc_eff  = (TIMER_INDEX != 0) ? lat_ctrl_reg[CTRL_CASCADE] : 1'b0;
            armed     = !en_reg && lat_ctrl_reg[CTRL_ENABLE];
        end
    end

    // Reload and count phases
    always_comb begin
        cnt_start = armed ? reload_eff : cnt_reg;
        hit       = ((cycle_count & prescale_mask(presc_eff)) == '0);
        inc       = en_eff && (casc_eff ? carry_in : hit);
        sum       = {1'b0, cnt_start} + {{COUNTER_WIDTH{1'b0}}, 1'b1};
        ovf       = exec && (item.opcode == OP_TICK) && inc && sum[COUNTER_WIDTH];
    end

    assign evt.overflow = ovf;
    assign evt.irq      = ovf && irq_eff;

    // Next state per item
    always_comb begin
        cnt_next        = cnt_reg;
        reload_next     = reload_reg;
        lat_reload_next = lat_reload_reg;
        pend_next       = pend_reg;
        lat_ctrl_next   = lat_ctrl_reg;
        ctrl_pend_next  = ctrl_pend_reg;
        presc_next      = presc_reg;
        casc_next       = casc_reg;
        irq_en_next     = irq_en_reg;
        en_next         = en_reg;
        if (exec) begin
            unique case (item.opcode)
                OP_TICK: begin
                    reload_next    = reload_eff;
                    pend_next      = 2'b00;
                    ctrl_pend_next = 1'b0;
                    presc_next     = presc_eff;
                    casc_next      = casc_eff;
                    irq_en_next    = irq_eff;
                    en_next        = en_eff;
                    if (!inc) begin
                        cnt_next = cnt_start;
                    end else if (sum[COUNTER_WIDTH]) begin
                        cnt_next = reload_eff;
                    end else begin
                        cnt_next = sum[COUNTER_WIDTH-1:0];
                    end
                end
                OP_RELOAD: begin
                    if (selected) begin
                        if (item.byte_lane) begin
                            lat_reload_next[15:8] = item.write_data;
                            pend_next[1]          = 1'b1;
                        end else begin
                            lat_reload_next[7:0] = item.write_data;
                            pend_next[0]         = 1'b1;
                        end
                    end
                end
                OP_CONTROL: begin
                    if (selected) begin
                        lat_ctrl_next  = item.write_data;
                        ctrl_pend_next = 1'b1;
                    end
                end
                OP_NOP: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            reload_reg     <= '0;
            lat_reload_reg <= '0;
            pend_reg       <= '0;
            lat_ctrl_reg   <= '0;
            ctrl_pend_reg  <= 1'b0;
            presc_reg      <= '0;
            casc_reg       <= 1'b0;
            irq_en_reg     <= 1'b0;
            en_reg         <= 1'b0;
        end else begin
            cnt_reg        <= cnt_next;
            reload_reg     <= reload_next;
            lat_reload_reg <= lat_reload_next;
            pend_reg       <= pend_next;
            lat_ctrl_reg   <= lat_ctrl_next;
            ctrl_pend_reg  <= ctrl_pend_next;
            presc_reg      <= presc_next;
            casc_reg       <= casc_next;
            irq_en_reg     <= irq_en_next;
            en_reg         <= en_next;
        end
    end

endmodule

@@ hdl/cascaded_prescaled_timer_bank_unit.sv @@
// Cascaded prescaled timer bank: input register, timer chain, result register.
// Each accepted item waits in the input register, then its result is registered.
// One item per cycle while m_ready holds; the cascade carry chain sets the cycle time.
// Reset: synchronous, active low; all timer state, the cycle count and the
// FIFO timer selects clear to zero at once, with no clearing pass.
// Depends on cptb_pkg and cptb_timer.
module cascaded_prescaled_timer_bank_unit #(
    parameter int NUM_TIMERS    = 4,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cptb_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output cptb_pkg::out_item_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [cptb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic                             cfg_wr_data
);
    import cptb_pkg::*;

    logic               in_valid_reg, in_valid_next;
    in_item_t           in_item_reg;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;
    logic [CYCLE_W-1:0] cycle_reg, cycle_next;
    logic               fifo_a_reg, fifo_b_reg;
    logic               exec;
    logic [NUM_TIMERS:0] carry;
    timer_evt_t         evt [NUM_TIMERS];
    logic [IRQ_W-1:0]   irq;

    // Handshake: execute when the result register is free or being drained
    assign exec    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || exec;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (exec) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (exec) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Timer chain
    assign carry[0] = 1'b0;
    for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
        cptb_timer #(
            .COUNTER_WIDTH(COUNTER_WIDTH),
            .TIMER_INDEX  (t)
        ) u_timer (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .exec       (exec),
            .item       (in_item_reg),
            .cycle_count(cycle_reg),
            .carry_in   (carry[t]),
            .evt        (evt[t])
        );
        assign carry[t+1] = evt[t].overflow;
    end

    // Only the low timers can report an irq
    for (genvar i = 0; i < IRQ_W; i++) begin : g_irq
        if (i < NUM_TIMERS) begin : g_on
            assign irq[i] = evt[i].irq;
        end else begin : g_off
            assign irq[i] = 1'b0;
        end
    end

    // Result and cycle count
    always_comb begin
        out_item_next              = out_item_reg;
        cycle_next                 = cycle_reg;
        if (exec) begin
            out_item_next.irq_pulses   = irq;
            out_item_next.fifo_a_pulse = fifo_a_reg ? evt[1].overflow : evt[0].overflow;
            out_item_next.fifo_b_pulse = fifo_b_reg ? evt[1].overflow : evt[0].overflow;
            if (in_item_reg.opcode == OP_TICK) begin
                cycle_next = cycle_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cycle_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cycle_reg     <= cycle_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        out_item_reg <= out_item_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_a_reg <= 1'b0;
            fifo_b_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FIFO_A_TIMER: fifo_a_reg <= cfg_wr_data;
                CFG_FIFO_B_TIMER: fifo_b_reg <= cfg_wr_data;
            endcase
        end
    end

`ifndef SYNTH
    // A write or idle item yields an all-zero result
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && in_item_reg.opcode != OP_TICK) |=> (m_valid && m_data == '0))
        else $error("non-tick item produced nonzero result");

    // Cycle count moves only on executed ticks
    a_cycle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(exec && in_item_reg.opcode == OP_TICK) |=> $stable(cycle_reg))
        else $error("cycle count moved without a tick");

    a_cycle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && in_item_reg.opcode == OP_TICK) |=>
        (cycle_reg == CYCLE_W'($past(cycle_reg) + 1'b1)))
        else $error("cycle count did not advance on tick");
`endif

endmodule
